@@ rtl/core/sorted_string_table_search_core_defines.svh @@
// Assertion macros for the sorted string table search core.
`ifndef SORTED_STRING_TABLE_SEARCH_CORE_DEFINES_SVH
`define SORTED_STRING_TABLE_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define SSTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sstbl assertion failed");
// Next-cycle implication, disabled in reset
`define SSTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sstbl assertion failed");
`else
`define SSTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SSTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/sstbl_pkg.sv @@
// Types, codes and constants shared by the sorted string table search core.
package sstbl_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAX_LEN_DEF = 64;
    localparam int QUEUE_DEPTH = 4;

    // Input kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
    } t_out;

    // Classified operation held in the queue
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       last;
    } t_qitem;

    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_qport;

    // 1-based position of a table index, masked to five bits
    function automatic logic [4:0] f_pos(input logic [31:0] idx);
        logic [31:0] p;
        p = idx + 32'd1;
        return p[4:0];
    endfunction

endpackage

@@ rtl/core/sstbl_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
module sstbl_front #(
    parameter int QD = sstbl_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sstbl_pkg::t_in     i_in_data,
    output sstbl_pkg::t_qport  o_q,
    input  logic               i_q_pop
);
    localparam int AW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    sstbl_pkg::t_qitem r_mem [QD];
    logic [AW-1:0]     r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]     r_cnt, n_cnt;
    sstbl_pkg::t_qitem w_item;
    logic              w_keep, w_push;

    // Classify: unused kind is dropped
    always_comb begin
        w_item.ch   = i_in_data.char_byte;
        w_item.last = i_in_data.last_byte;
        w_item.op   = sstbl_pkg::OP_CLEAR;
        w_keep      = 1'b1;
        unique case (i_in_data.kind)
            sstbl_pkg::KIND_CLEAR:  w_item.op = sstbl_pkg::OP_CLEAR;
            sstbl_pkg::KIND_INSERT: w_item.op = sstbl_pkg::OP_INSERT;
            sstbl_pkg::KIND_LOOKUP: w_item.op = sstbl_pkg::OP_LOOKUP;
            default:                w_keep    = 1'b0;
        endcase
    end

    assign o_in_ready = (r_cnt != CW'(QD));
    assign w_push     = i_in_valid && o_in_ready && w_keep;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == AW'(QD - 1)) ? '0 : r_wp + AW'(1);
        end
        if (i_q_pop) begin
            n_rp = (r_rp == AW'(QD - 1)) ? '0 : r_rp + AW'(1);
        end
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_mem[r_rp];

endmodule

@@ rtl/core/sstbl_back.sv @@
// Back end: name buffer, sorted table, insertion sort and binary search.
module sstbl_back #(
    parameter int ENTRIES = sstbl_pkg::ENTRIES_DEF,
    parameter int MAX_LEN = sstbl_pkg::MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sstbl_pkg::t_qport  i_q,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sstbl_pkg::t_out    o_out_data
);
    localparam int EW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = $clog2(MAX_LEN);
    localparam int SW = CW + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEN  = 9'b000000010,
        S_CLENW = 9'b000000100,
        S_CRD   = 9'b000001000,
        S_CCMP  = 9'b000010000,
        S_KRD   = 9'b000100000,
        S_KWR   = 9'b001000000,
        S_WRD   = 9'b010000000,
        S_WWR   = 9'b100000000
    } t_state;

    // Memories
    logic [7:0]    m_store [ENTRIES][MAX_LEN];
    logic [7:0]    m_inc   [MAX_LEN];
    logic [LW-1:0] m_len   [ENTRIES];
    logic [7:0]    r_st_rd, r_inc_rd;
    logic [LW-1:0] r_len_rd;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [LW-1:0]        r_ilen, n_ilen;
    logic                 r_tl, n_tl;
    logic                 r_mode, n_mode;
    logic [EW-1:0]        r_j, n_j, r_e, n_e;
    logic [LW-1:0]        r_i, n_i, r_elen, n_elen;
    logic signed [SW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic                 r_out_valid, n_out_valid;
    sstbl_pkg::t_out      r_out, n_out;

    logic                 st_we, inc_we, len_we;
    logic [7:0]           st_wd;
    logic [LW-1:0]        len_wd, cmp_n;
    logic                 cmp_done, cmp_lt, cmp_eq;
    logic [CW-1:0]        cm1;
    logic signed [SW-1:0] e_s, s_lo, s_hi;
    logic signed [SW:0]   s_sum;

    // Store reads: row under compare or copy, byte index r_i
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_store[r_j][r_i[IW-1:0]] <= st_wd;
        end
        r_st_rd <= m_store[r_e][r_i[IW-1:0]];
    end

    // Incoming name buffer
    always_ff @(posedge i_clk) begin
        if (inc_we) begin
            m_inc[r_ilen[IW-1:0]] <= i_q.item.ch;
        end
        r_inc_rd <= m_inc[r_i[IW-1:0]];
    end

    // Entry lengths
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            m_len[r_j] <= len_wd;
        end
        r_len_rd <= m_len[r_e];
    end

    // Byte compare of incoming name against entry r_e
    always_comb begin
        cmp_n    = (r_ilen < r_elen) ? r_ilen : r_elen;
        cmp_done = 1'b0;
        cmp_lt   = 1'b0;
        cmp_eq   = 1'b0;
        if (r_state == S_CRD) begin
            cmp_done = (r_i == cmp_n);
            cmp_lt   = (r_ilen < r_elen);
            cmp_eq   = (r_ilen == r_elen);
        end else if (r_state == S_CCMP) begin
            cmp_done = (r_inc_rd != r_st_rd);
            cmp_lt   = (r_inc_rd < r_st_rd);
        end
    end

    // Binary search bounds after a mismatch
    always_comb begin
        cm1   = r_count - CW'(1);
        e_s   = signed'({{(SW-EW){1'b0}}, r_e});
        s_lo  = cmp_lt ? r_lo : e_s + SW'(1);
        s_hi  = cmp_lt ? e_s - SW'(1) : r_hi;
        s_sum = {s_lo[SW-1], s_lo} + {s_hi[SW-1], s_hi};
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ilen      = r_ilen;
        n_tl        = r_tl;
        n_mode      = r_mode;
        n_j         = r_j;
        n_e         = r_e;
        n_i         = r_i;
        n_elen      = r_elen;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        st_we       = 1'b0;
        st_wd       = r_st_rd;
        inc_we      = 1'b0;
        len_we      = 1'b0;
        len_wd      = r_elen;
        o_q_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q.item.op == sstbl_pkg::OP_CLEAR) begin
                        n_count = '0;
                        n_ilen  = '0;
                        n_tl    = 1'b0;
                    end else begin
                        if (r_ilen < LW'(MAX_LEN)) begin
                            inc_we = 1'b1;
                            n_ilen = r_ilen + LW'(1);
                        end else begin
                            n_tl = 1'b1;
                        end
                        if (i_q.item.last) begin
                            if (r_tl || r_ilen == LW'(MAX_LEN)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{sstbl_pkg::ST_TOO_LONG, 5'd0};
                                n_ilen      = '0;
                                n_tl        = 1'b0;
                            end else if (i_q.item.op == sstbl_pkg::OP_INSERT) begin
                                n_mode = 1'b1;
                                n_i    = '0;
                                if (r_count == CW'(ENTRIES)) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{sstbl_pkg::ST_FULL, 5'd0};
                                    n_ilen      = '0;
                                end else if (r_count == '0) begin
                                    n_j     = '0;
                                    n_state = S_WRD;
                                end else begin
                                    n_j     = EW'(r_count);
                                    n_e     = EW'(cm1);
                                    n_state = S_CLEN;
                                end
                            end else begin
                                n_mode = 1'b0;
                                if (r_count == '0) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{sstbl_pkg::ST_NOT_FOUND, 5'd0};
                                    n_ilen      = '0;
                                end else begin
                                    n_lo    = '0;
                                    n_hi    = signed'({1'b0, cm1});
                                    n_e     = EW'(cm1 >> 1);
                                    n_state = S_CLEN;
                                end
                            end
                        end
                    end
                end
            end
            S_CLEN: begin
                n_state = S_CLENW;
            end
            S_CLENW: begin
                n_elen  = r_len_rd;
                n_i     = '0;
                n_state = S_CRD;
            end
            S_CRD, S_CCMP: begin
                if (!cmp_done) begin
                    if (r_state == S_CRD) begin
                        n_state = S_CCMP;
                    end else begin
                        n_i     = r_i + LW'(1);
                        n_state = S_CRD;
                    end
                end else if (r_mode) begin
                    // Insert: shift entry up while it sorts above the new name
                    n_i     = '0;
                    n_state = cmp_lt ? S_KRD : S_WRD;
                end else if (cmp_eq) begin
                    n_out_valid = 1'b1;
                    n_out       = '{sstbl_pkg::ST_OK, sstbl_pkg::f_pos(32'(r_e))};
                    n_ilen      = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_lo = s_lo;
                    n_hi = s_hi;
                    if (s_lo <= s_hi) begin
                        n_e     = EW'(s_sum >>> 1);
                        n_state = S_CLEN;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{sstbl_pkg::ST_NOT_FOUND, 5'd0};
                        n_ilen      = '0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_KRD: begin
                if (r_i == r_elen) begin
                    len_we = 1'b1;
                    len_wd = r_elen;
                    n_j    = r_j - EW'(1);
                    n_i    = '0;
                    if (r_j > EW'(1)) begin
                        n_e     = r_j - EW'(2);
                        n_state = S_CLEN;
                    end else begin
                        n_state = S_WRD;
                    end
                end else begin
                    n_state = S_KWR;
                end
            end
            S_KWR: begin
                st_we   = 1'b1;
                st_wd   = r_st_rd;
                n_i     = r_i + LW'(1);
                n_state = S_KRD;
            end
            S_WRD: begin
                if (r_i == r_ilen) begin
                    len_we      = 1'b1;
                    len_wd      = r_ilen;
                    n_count     = r_count + CW'(1);
                    n_out_valid = 1'b1;
                    n_out       = '{sstbl_pkg::ST_OK, sstbl_pkg::f_pos(32'(r_j))};
                    n_ilen      = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_WWR;
                end
            end
            S_WWR: begin
                st_we   = 1'b1;
                st_wd   = r_inc_rd;
                n_i     = r_i + LW'(1);
                n_state = S_WRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ilen      <= '0;
            r_tl        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ilen      <= n_ilen;
            r_tl        <= n_tl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_j    <= n_j;
        r_e    <= n_e;
        r_i    <= n_i;
        r_elen <= n_elen;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/sorted_string_table_search_core.sv @@
// A non-final byte is taken in the back end's idle state; a final byte gives a result from idle or starts the work.
// Lookup: about log2(count) compares, each byte by byte over one store read port.
// Insert: per shifted entry a compare plus a byte-by-byte copy, then a byte-by-byte write of the new name.
// A 4-deep queue takes input while the back end works; one result register at the output.
// Reset (synchronous, active low) empties the table, the name buffer and the queue.
`include "sorted_string_table_search_core_defines.svh"
module sorted_string_table_search_core #(
    parameter int ENTRIES = sstbl_pkg::ENTRIES_DEF,
    parameter int MAX_LEN = sstbl_pkg::MAX_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sstbl_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sstbl_pkg::t_out o_out_data
);
    sstbl_pkg::t_qport w_q;
    logic              w_q_pop;

    sstbl_front #(
        .QD (sstbl_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q        (w_q),
        .i_q_pop    (w_q_pop)
    );

    sstbl_back #(
        .ENTRIES (ENTRIES),
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_q),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Checks
    `SSTS_ASSERT_IMPL(a_pop_needs_free_out, i_clk, i_rst_n, w_q_pop, !o_out_valid && w_q.valid)
    `SSTS_ASSERT_IMPL(a_pos_zero_on_fail, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != sstbl_pkg::ST_OK, o_out_data.position == 5'd0)
    `SSTS_ASSERT_NEXT(a_no_pop_while_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, !w_q_pop)

endmodule

@@ dv/sstbl_checker.sv @@
// Checker for the sorted string table search core: predicts and compares results.
`timescale 1ns / 100ps
module sstbl_checker #(
    parameter int ENTRIES = sstbl_pkg::ENTRIES_DEF,
    parameter int MAX_LEN = sstbl_pkg::MAX_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  sstbl_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  sstbl_pkg::t_out i_out_data,
    output int              o_fail_count,
    output int              o_pending
);
    // Predicted table contents
    logic [7:0] tbl_name [ENTRIES][MAX_LEN];
    int         tbl_len  [ENTRIES];
    int         tbl_count;
    logic [7:0] buf_name [MAX_LEN];
    int         buf_len;
    bit         buf_overlong;

    sstbl_pkg::t_out result_queue[$];

    // Compare the incoming name with table entry e
    function automatic int name_order(int e);
        int n;
        n = (buf_len < tbl_len[e]) ? buf_len : tbl_len[e];
        for (int i = 0; i < n; i++) begin
            if (buf_name[i] != tbl_name[e][i]) return (buf_name[i] < tbl_name[e][i]) ? -1 : 1;
        end
        if (buf_len == tbl_len[e]) return 0;
        return (buf_len < tbl_len[e]) ? -1 : 1;
    endfunction

    function automatic sstbl_pkg::t_out place_name();
        sstbl_pkg::t_out r;
        int              j;
        if (tbl_count >= ENTRIES) begin
            r.status = sstbl_pkg::ST_FULL;
            r.position = '0;
            return r;
        end
        j = tbl_count;
        while (j > 0 && name_order(j - 1) < 0) begin
            tbl_name[j] = tbl_name[j - 1];
            tbl_len[j] = tbl_len[j - 1];
            j--;
        end
        for (int i = 0; i < MAX_LEN; i++) tbl_name[j][i] = buf_name[i];
        tbl_len[j] = buf_len;
        tbl_count++;
        r.status = sstbl_pkg::ST_OK;
        r.position = 5'(j + 1);
        return r;
    endfunction

    function automatic sstbl_pkg::t_out find_name();
        sstbl_pkg::t_out r;
        int              lo;
        int              hi;
        int              mid;
        int              c;
        lo = 0;
        hi = tbl_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            c = name_order(mid);
            if (c == 0) begin
                r.status = sstbl_pkg::ST_OK;
                r.position = 5'(mid + 1);
                return r;
            end
            if (c > 0) lo = mid + 1;
            else hi = mid - 1;
        end
        r.status = sstbl_pkg::ST_NOT_FOUND;
        r.position = '0;
        return r;
    endfunction

    // Predict on each input transaction, compare on each output transaction
    always @(posedge i_clk) begin
        sstbl_pkg::t_out r;
        sstbl_pkg::t_out x;
        if (!i_rst_n) begin
            tbl_count = 0;
            buf_len = 0;
            buf_overlong = 0;
            result_queue.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == sstbl_pkg::KIND_CLEAR) begin
                    tbl_count = 0;
                    buf_len = 0;
                    buf_overlong = 0;
                end else if (i_in_data.kind == sstbl_pkg::KIND_INSERT ||
                             i_in_data.kind == sstbl_pkg::KIND_LOOKUP) begin
                    if (buf_len < MAX_LEN) begin
                        buf_name[buf_len] = i_in_data.char_byte;
                        buf_len++;
                    end else begin
                        buf_overlong = 1;
                    end
                    if (i_in_data.last_byte) begin
                        if (buf_overlong) begin
                            r.status = sstbl_pkg::ST_TOO_LONG;
                            r.position = '0;
                        end else if (i_in_data.kind == sstbl_pkg::KIND_INSERT) begin
                            r = place_name();
                        end else begin
                            r = find_name();
                        end
                        result_queue.push_back(r);
                        buf_len = 0;
                        buf_overlong = 0;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result status=%0d pos=%0d",
                                 i_out_data.status, i_out_data.position);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    x = result_queue.pop_front();
                    if (x.status !== i_out_data.status ||
                        x.position !== i_out_data.position) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected status=%0d pos=%0d, %s%0d pos=%0d",
                                     x.status, x.position, "got status=",
                                     i_out_data.status, i_out_data.position);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= result_queue.size();
        end
    end
endmodule

@@ dv/tb.sv @@
// Testbench top for the sorted string table search core: stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    localparam int MAXL = sstbl_pkg::MAX_LEN_DEF;
    // Kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            in_valid = 0;
    logic            in_ready;
    sstbl_pkg::t_in  in_data = '0;
    logic            out_valid;
    logic            out_ready = 0;
    sstbl_pkg::t_out out_data;
    int              fail_count;
    int              pending;
    bit              long_hold = 0;
    bit              stall_mode = 0;

    // Pool of short names so lookups hit and inserts collide
    logic [7:0] name_pool [8][6];
    int         pool_len [8];

    always #5 i_clk = ~i_clk;

    sorted_string_table_search_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    sstbl_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stall pattern, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (long_hold) out_ready <= 0;
        else if (!stall_mode) out_ready <= 1;
        else out_ready <= ($urandom_range(3) != 0);
    end

    initial begin
        #50_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // One input transaction, with an optional gap after it
    task automatic send_byte(logic [1:0] k, logic [7:0] c, logic l);
        in_valid <= 1;
        in_data <= '{kind: k, char_byte: c, last_byte: l};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if ($urandom_range(7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_name(logic [1:0] k, int len, bit from_pool, int idx);
        for (int i = 0; i < len; i++)
            send_byte((i == len - 1) ? k : 2'($urandom_range(1, 2)),
                      from_pool ? name_pool[idx][i] : 8'($urandom_range(255)),
                      i == len - 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int sel;
        int n;
        for (int p = 0; p < 8; p++) begin
            pool_len[p] = $urandom_range(1, 6);
            for (int i = 0; i < 6; i++) name_pool[p][i] = 8'($urandom_range(0, 3) * 85);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, prefix order, mixed kinds, unused kind, overlong, full
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'hFF, 1);
        send_byte(sstbl_pkg::KIND_INSERT, 8'hFF, 1);
        send_byte(sstbl_pkg::KIND_INSERT, 8'h00, 1);
        send_byte(sstbl_pkg::KIND_INSERT, 8'h00, 0);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'h01, 0);
        send_byte(KIND_UNUSED, 8'hAA, 1);
        send_byte(sstbl_pkg::KIND_INSERT, 8'h80, 1);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'h00, 1);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'hFF, 1);
        send_byte(sstbl_pkg::KIND_INSERT, 8'h55, 0);
        send_byte(sstbl_pkg::KIND_CLEAR, 8'h00, 0);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'hFF, 1);
        for (int i = 0; i < MAXL; i++)
            send_byte(sstbl_pkg::KIND_INSERT, 8'h41, i == MAXL - 1);
        for (int i = 0; i < MAXL; i++)
            send_byte(sstbl_pkg::KIND_LOOKUP, 8'h41, i == MAXL - 1);
        for (int i = 0; i <= MAXL; i++)
            send_byte(sstbl_pkg::KIND_INSERT, 8'h42, i == MAXL);
        for (int i = 0; i <= MAXL; i++)
            send_byte(sstbl_pkg::KIND_LOOKUP, 8'h42, i == MAXL);
        drain();
        for (int i = 0; i < 17; i++) send_byte(sstbl_pkg::KIND_INSERT, 8'(i * 15), 1);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'd0, 1);
        send_byte(sstbl_pkg::KIND_LOOKUP, 8'd240, 1);
        drain();

        // Long receiver hold-off while input keeps coming
        long_hold <= 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                long_hold <= 0;
            end
            for (int i = 0; i < 20; i++) send_byte(sstbl_pkg::KIND_LOOKUP, 8'(i), 1);
        join
        drain();

        // Random: mostly pool names in insert/lookup, some noise and clears
        n = 0;
        while (n < 1100) begin
            stall_mode <= ($urandom_range(3) != 0);
            sel = $urandom_range(99);
            if (sel < 3) begin
                send_byte(sstbl_pkg::KIND_CLEAR, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                n++;
            end else if (sel < 5) begin
                send_byte(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (sel < 7) begin
                send_name(2'($urandom_range(1, 2)), MAXL + $urandom_range(0, 2), 0, 0);
                n += MAXL;
            end else if (sel < 20) begin
                sel = $urandom_range(1, 10);
                send_name(2'($urandom_range(1, 2)), sel, 0, 0);
                n += sel;
            end else begin
                sel = $urandom_range(7);
                send_name(($urandom_range(2) == 0) ? sstbl_pkg::KIND_INSERT
                                                   : sstbl_pkg::KIND_LOOKUP,
                          pool_len[sel], 1, sel);
                n += pool_len[sel];
            end
            if ($urandom_range(40) == 0) drain();
        end
        drain();
        if (fail_count == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
